@@ src/toc_pkg.sv @@
// Shared types and constants for the tile occupancy census block.
package toc_pkg;
   localparam int unsigned CfgIdxW = 2;
   localparam logic [CfgIdxW-1:0] CSR_SOURCE_GROUPS = 2'd0;
   localparam logic [CfgIdxW-1:0] CSR_DESTINATION_GROUPS = 2'd1;
   localparam logic [CfgIdxW-1:0] CSR_EDGE_TOTAL = 2'd2;
   localparam int unsigned CsrDataW = 13;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_SELECT = 2'd1,
      OP_EDGE = 2'd2,
      OP_FINISH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      OWN_NONE = 2'd0,
      OWN_MATRIX = 2'd1,
      OWN_RESIDUAL = 2'd2
   } owner_type;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_GROUP_RANGE = 3'd1;
   localparam logic [2:0] ST_EDGE_RANGE = 3'd2;
   localparam logic [2:0] ST_EDGE_REPEATED = 3'd3;
   localparam logic [2:0] ST_TOTALS = 3'd4;
   localparam logic [2:0] ST_GRID = 3'd5;
   localparam logic [2:0] ST_EARLIER = 3'd6;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_WRITE = 4'b0100,
      S_CLEAR = 4'b1000
   } state_type;
endpackage

@@ src/tile_occupancy_census.sv @@
// Tile occupancy census: top level with memory read-modify-write control.
// Select and finish answer from the READ state; an edge reads in READ and answers from WRITE.
// Busy stays high until a word is answered, so a new word is taken only after the last one.
// Clear sweeps max(MAX_TILES*4, MAX_EDGES) entries, one per cycle, before answering.
// Reset runs the same sweep with busy high; the receiver cannot stall.
module tile_occupancy_census
   import toc_pkg::*;
#(
   parameter int unsigned MAX_TILES = 1024,
   parameter int unsigned MAX_EDGES = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_operation,
   input  logic [9:0]          req_tile_index,
   input  logic                req_tile_selected,
   input  logic [9:0]          req_source_group,
   input  logic [3:0]          req_source_position,
   input  logic [9:0]          req_destination_group,
   input  logic [3:0]          req_destination_position,
   input  logic [11:0]         req_logical_edge,
   input  logic                csr_write,
   input  logic [CfgIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_data,
   output logic                rsp_valid,
   output logic [1:0]          rsp_owner,
   output logic                rsp_first_hit,
   output logic [8:0]          rsp_unique_count,
   output logic [12:0]         rsp_matrix_total,
   output logic [12:0]         rsp_residual_total,
   output logic [2:0]          rsp_status
);
   localparam int unsigned WordDepth = MAX_TILES * 4;
   localparam int unsigned TileW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
   localparam int unsigned WordW = $clog2(WordDepth);
   localparam int unsigned EdgeW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int unsigned SweepN = (WordDepth > MAX_EDGES) ? WordDepth : MAX_EDGES;
   localparam int unsigned SweepW = $clog2(SweepN + 1);

   logic [63:0] occ_mem [WordDepth];
   logic [8:0]  cnt_mem [MAX_TILES];
   logic        sel_mem [MAX_TILES];
   logic [1:0]  own_mem [MAX_EDGES];

   state_type state_ff, state_in;
   logic [10:0] sgroups_ff;
   logic [10:0] dgroups_ff;
   logic [12:0] etotal_ff;
   logic [12:0] mcount_ff, mcount_in;
   logic [12:0] rcount_ff, rcount_in;
   logic        err_ff, err_in;
   logic [SweepW-1:0] sweep_ff, sweep_in;
   logic        reset_sweep_ff;

   op_type      op_ff;
   logic        selbit_ff;
   logic [20:0] tile_ff;
   logic [7:0]  bit_ff;
   logic [12:0] edge_ff;
   logic [2:0]  pre_ff;
   logic [TileW-1:0] sel_idx_ff;
   logic        sel_ok_ff;

   logic [63:0] occ_rd_ff;
   logic [8:0]  cnt_rd_ff;
   logic        sel_rd_ff;
   logic [1:0]  own_rd_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  owner_ff, owner_in;
   logic        first_ff, first_in;
   logic [8:0]  unique_ff, unique_in;
   logic [2:0]  status_ff, status_in;

   logic [21:0] grid_prod;
   logic        grid_big;
   logic [20:0] tile_calc;
   logic [2:0]  pre_calc;
   logic        accept;

   assign accept = start && !busy;
   assign busy = (state_ff != S_IDLE);
   assign grid_prod = 22'(sgroups_ff) * 22'(dgroups_ff);
   assign grid_big = grid_prod > 22'(MAX_TILES);
   assign tile_calc = 21'(req_destination_group) * 21'(sgroups_ff)
      + 21'(req_source_group);

   always_comb begin
      if (err_ff) begin
         pre_calc = ST_EARLIER;
      end else if (grid_big) begin
         pre_calc = ST_GRID;
      end else if (11'(req_source_group) >= sgroups_ff
            || 11'(req_destination_group) >= dgroups_ff) begin
         pre_calc = ST_GROUP_RANGE;
      end else if (13'(req_logical_edge) >= etotal_ff
            || 21'(req_logical_edge) >= 21'(MAX_EDGES)) begin
         pre_calc = ST_EDGE_RANGE;
      end else begin
         pre_calc = ST_OK;
      end
   end

   // Capture the word and register the config.
   always_ff @(posedge clock) begin
      if (reset) begin
         sgroups_ff <= 11'd1;
         dgroups_ff <= 11'd1;
         etotal_ff <= 13'd1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SOURCE_GROUPS: sgroups_ff <= csr_data[10:0];
            CSR_DESTINATION_GROUPS: dgroups_ff <= csr_data[10:0];
            CSR_EDGE_TOTAL: etotal_ff <= csr_data;
            default: ;
         endcase
      end
      if (accept) begin
         op_ff <= op_type'(req_operation);
         selbit_ff <= req_tile_selected;
         tile_ff <= tile_calc;
         bit_ff <= {req_destination_position, req_source_position};
         edge_ff <= 13'(req_logical_edge);
         pre_ff <= pre_calc;
         sel_idx_ff <= TileW'(req_tile_index);
         sel_ok_ff <= 32'(req_tile_index) < MAX_TILES;
      end
   end

   logic [WordW-1:0] wadr;
   logic [TileW-1:0] tadr;
   logic [EdgeW-1:0] eadr;
   logic             do_write;
   assign wadr = WordW'({tile_ff, bit_ff[7:6]});
   assign tadr = TileW'(tile_ff);
   assign eadr = EdgeW'(edge_ff);
   assign do_write = (state_ff == S_WRITE) && (op_ff == OP_EDGE)
      && (pre_ff == ST_OK) && (own_rd_ff == OWN_NONE);

   logic [63:0] mask;
   logic        fresh;
   logic [1:0]  own_new;
   assign mask = 64'd1 << bit_ff[5:0];
   assign fresh = (occ_rd_ff & mask) == 64'd0;
   assign own_new = (fresh && sel_rd_ff) ? OWN_MATRIX : OWN_RESIDUAL;

   // Memories: read in READ, write back in WRITE (a select bit is written in READ), zero during sweep.
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         if (32'(sweep_ff) < WordDepth) occ_mem[WordW'(sweep_ff)] <= 64'd0;
         if (32'(sweep_ff) < MAX_TILES) begin
            cnt_mem[TileW'(sweep_ff)] <= 9'd0;
            sel_mem[TileW'(sweep_ff)] <= 1'b0;
         end
         if (32'(sweep_ff) < MAX_EDGES) own_mem[EdgeW'(sweep_ff)] <= OWN_NONE;
      end else if (do_write) begin
         own_mem[eadr] <= own_new;
         if (fresh) begin
            occ_mem[wadr] <= occ_rd_ff | mask;
            cnt_mem[tadr] <= cnt_rd_ff + 9'd1;
         end
      end else if (state_ff == S_READ && op_ff == OP_SELECT && sel_ok_ff) begin
         sel_mem[sel_idx_ff] <= selbit_ff;
      end
      occ_rd_ff <= occ_mem[wadr];
      cnt_rd_ff <= cnt_mem[tadr];
      sel_rd_ff <= sel_mem[tadr];
      own_rd_ff <= own_mem[eadr];
   end

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      mcount_in = mcount_ff;
      rcount_in = rcount_ff;
      err_in = err_ff;
      rsp_valid_in = 1'b0;
      owner_in = OWN_NONE;
      first_in = 1'b0;
      unique_in = 9'd0;
      status_in = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (op_type'(req_operation) == OP_CLEAR) ? S_CLEAR : S_READ;
               sweep_in = '0;
            end
         end
         S_READ: begin
            if (op_ff == OP_EDGE) begin
               state_in = S_WRITE;
            end else begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
               if (op_ff == OP_SELECT) begin
                  status_in = err_ff ? ST_EARLIER : ST_OK;
               end else if (err_ff) begin
                  status_in = ST_EARLIER;
               end else if (grid_big) begin
                  status_in = ST_GRID;
                  err_in = 1'b1;
               end else if (etotal_ff == 13'd0
                     || 14'(mcount_ff) + 14'(rcount_ff) != 14'(etotal_ff)) begin
                  status_in = ST_TOTALS;
                  err_in = 1'b1;
               end
            end
         end
         S_WRITE: begin
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
            if (pre_ff != ST_OK) begin
               status_in = pre_ff;
               if (pre_ff != ST_EARLIER) err_in = 1'b1;
            end else if (own_rd_ff != OWN_NONE) begin
               status_in = ST_EDGE_REPEATED;
               err_in = 1'b1;
            end else begin
               owner_in = own_new;
               first_in = fresh;
               unique_in = fresh ? cnt_rd_ff + 9'd1 : cnt_rd_ff;
               if (own_new == OWN_MATRIX) mcount_in = mcount_ff + 13'd1;
               else rcount_in = rcount_ff + 13'd1;
            end
         end
         S_CLEAR: begin
            sweep_in = sweep_ff + SweepW'(1);
            if (32'(sweep_ff) == SweepN - 1) begin
               state_in = S_IDLE;
               rsp_valid_in = !reset_sweep_ff;
               mcount_in = '0;
               rcount_in = '0;
               err_in = 1'b0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         sweep_ff <= '0;
         mcount_ff <= '0;
         rcount_ff <= '0;
         err_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         reset_sweep_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         mcount_ff <= mcount_in;
         rcount_ff <= rcount_in;
         err_ff <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) reset_sweep_ff <= 1'b0;
      end
      owner_ff <= owner_in;
      first_ff <= first_in;
      unique_ff <= unique_in;
      status_ff <= status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_owner = owner_ff;
   assign rsp_first_hit = first_ff;
   assign rsp_unique_count = unique_ff;
   assign rsp_matrix_total = mcount_ff;
   assign rsp_residual_total = rcount_ff;
   assign rsp_status = status_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(accept)) else $error("result too early");
   a_counts_move_one: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff) == S_WRITE |-> $countones({mcount_ff != $past(mcount_ff),
      rcount_ff != $past(rcount_ff)}) <= 1) else $error("both totals moved");
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(state_ff) == S_CLEAR |-> mcount_ff == 13'd0
      && rcount_ff == 13'd0) else $error("clear left totals");
`endif
endmodule

@@ dv/tile_occupancy_census_tb.sv @@
// Self-checking testbench for the tile occupancy census block.
module tile_occupancy_census_tb;
   import toc_pkg::*;

   localparam int NumTiles = 1024;
   localparam int NumEdges = 4096;
   localparam int StallLimit = 20000;

   typedef struct {
      op_type      op;
      logic [9:0]  tile;
      logic        sel;
      logic [9:0]  sgrp;
      logic [3:0]  spos;
      logic [9:0]  dgrp;
      logic [3:0]  dpos;
      logic [11:0] eid;
   } census_word;

   typedef struct {
      owner_type   owner;
      logic        first;
      logic [8:0]  uniq;
      logic [12:0] mtot;
      logic [12:0] rtot;
      logic [2:0]  st;
   } census_result;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_operation = 0;
   logic [9:0] req_tile_index = 0;
   logic req_tile_selected = 0;
   logic [9:0] req_source_group = 0;
   logic [3:0] req_source_position = 0;
   logic [9:0] req_destination_group = 0;
   logic [3:0] req_destination_position = 0;
   logic [11:0] req_logical_edge = 0;
   logic csr_write = 0;
   logic [CfgIdxW-1:0] csr_index = CSR_SOURCE_GROUPS;
   logic [CsrDataW-1:0] csr_data = 0;
   logic rsp_valid;
   logic [1:0] rsp_owner;
   logic rsp_first_hit;
   logic [8:0] rsp_unique_count;
   logic [12:0] rsp_matrix_total;
   logic [12:0] rsp_residual_total;
   logic [2:0] rsp_status;

   tile_occupancy_census dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // census model state
   logic [255:0] occ_map [NumTiles];
   logic [8:0]   tile_count [NumTiles];
   logic         tile_sel [NumTiles];
   logic [1:0]   edge_owner [NumEdges];
   logic [12:0]  matrix_cnt, residual_cnt;
   logic         sticky_err;
   logic [10:0]  src_groups = 1, dst_groups = 1;
   logic [12:0]  edge_goal = 1;

   census_word   pending_words [$];
   census_result expected_results [$];
   census_word   cur;
   int           gap = 0;
   bit           failed = 0;
   int           stall = 0;
   int           issued = 0;

   function automatic void wipe_census();
      for (int i = 0; i < NumTiles; i++) begin
         occ_map[i] = '0;
         tile_count[i] = '0;
         tile_sel[i] = 1'b0;
      end
      for (int i = 0; i < NumEdges; i++) edge_owner[i] = OWN_NONE;
      matrix_cnt = '0;
      residual_cnt = '0;
      sticky_err = 1'b0;
   endfunction

   function automatic census_result census_outcome(census_word w);
      census_result r;
      int tile, pos;
      bit grid_big;
      grid_big = int'(src_groups) * int'(dst_groups) > NumTiles;
      r.owner = OWN_NONE;
      r.first = 1'b0;
      r.uniq = '0;
      r.st = ST_OK;
      case (w.op)
         OP_CLEAR: wipe_census();
         OP_SELECT: begin
            tile_sel[w.tile] = w.sel;
            r.st = sticky_err ? ST_EARLIER : ST_OK;
         end
         OP_EDGE: begin
            if (sticky_err) r.st = ST_EARLIER;
            else if (grid_big) r.st = ST_GRID;
            else if (w.sgrp >= src_groups || w.dgrp >= dst_groups) r.st = ST_GROUP_RANGE;
            else if (w.eid >= edge_goal) r.st = ST_EDGE_RANGE;
            else if (edge_owner[w.eid] != OWN_NONE) r.st = ST_EDGE_REPEATED;
            else begin
               tile = int'(w.dgrp) * int'(src_groups) + int'(w.sgrp);
               pos = int'(w.dpos) * 16 + int'(w.spos);
               if (!occ_map[tile][pos]) begin
                  occ_map[tile][pos] = 1'b1;
                  tile_count[tile] = tile_count[tile] + 9'd1;
                  r.first = 1'b1;
               end
               if (r.first && tile_sel[tile]) begin
                  r.owner = OWN_MATRIX;
                  matrix_cnt = matrix_cnt + 13'd1;
               end else begin
                  r.owner = OWN_RESIDUAL;
                  residual_cnt = residual_cnt + 13'd1;
               end
               edge_owner[w.eid] = r.owner;
               r.uniq = tile_count[tile];
            end
            if (r.st != ST_OK && r.st != ST_EARLIER) sticky_err = 1'b1;
         end
         default: begin
            if (sticky_err) r.st = ST_EARLIER;
            else if (grid_big) r.st = ST_GRID;
            else if (edge_goal == 0 || 14'(matrix_cnt) + 14'(residual_cnt) != 14'(edge_goal))
               r.st = ST_TOTALS;
            if (r.st == ST_TOTALS || r.st == ST_GRID) sticky_err = 1'b1;
         end
      endcase
      r.mtot = matrix_cnt;
      r.rtot = residual_cnt;
      return r;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 65) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_results.push_back(census_outcome(cur));
         end
         if (!start || !busy) begin
            if (gap > 0) begin
               gap--;
               start <= 1'b0;
            end else if (pending_words.size() > 0) begin
               cur = pending_words.pop_front();
               req_operation <= cur.op;
               req_tile_index <= cur.tile;
               req_tile_selected <= cur.sel;
               req_source_group <= cur.sgrp;
               req_source_position <= cur.spos;
               req_destination_group <= cur.dgrp;
               req_destination_position <= cur.dpos;
               req_logical_edge <= cur.eid;
               start <= 1'b1;
               gap = pick_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      census_result e;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d",
                     $time, rsp_status);
            failed = 1;
         end else begin
            e = expected_results.pop_front();
            if (rsp_owner !== e.owner) begin
               $display("%0t: owner expected %0d actual %0d", $time, e.owner, rsp_owner);
               failed = 1;
            end
            if (rsp_first_hit !== e.first) begin
               $display("%0t: first_hit expected %0d actual %0d", $time, e.first,
                        rsp_first_hit);
               failed = 1;
            end
            if (rsp_unique_count !== e.uniq) begin
               $display("%0t: unique_count expected %0d actual %0d", $time, e.uniq,
                        rsp_unique_count);
               failed = 1;
            end
            if (rsp_matrix_total !== e.mtot) begin
               $display("%0t: matrix_total expected %0d actual %0d", $time, e.mtot,
                        rsp_matrix_total);
               failed = 1;
            end
            if (rsp_residual_total !== e.rtot) begin
               $display("%0t: residual_total expected %0d actual %0d", $time, e.rtot,
                        rsp_residual_total);
               failed = 1;
            end
            if (rsp_status !== e.st) begin
               $display("%0t: status expected %0d actual %0d", $time, e.st, rsp_status);
               failed = 1;
            end
         end
      end
      if ((start && !busy) || rsp_valid) stall = 0;
      else stall++;
      if (stall >= StallLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic census_word make_word(op_type op, int tile, bit sel, int sg, int sp,
                                            int dg, int dp, int eid);
      census_word w;
      w.op = op;
      w.tile = 10'(tile);
      w.sel = sel;
      w.sgrp = 10'(sg);
      w.spos = 4'(sp);
      w.dgrp = 10'(dg);
      w.dpos = 4'(dp);
      w.eid = 12'(eid);
      return w;
   endfunction

   function automatic census_word noise_word();
      return make_word(op_type'($urandom_range(1, 3)), $urandom_range(0, 1023),
                       $urandom_range(0, 1), $urandom_range(0, 1023),
                       $urandom_range(0, 15), $urandom_range(0, 1023),
                       $urandom_range(0, 15), $urandom_range(0, 4095));
   endfunction

   function automatic int group_pick(int reg_val);
      int lim;
      lim = reg_val > 1024 ? 1024 : reg_val;
      if (lim == 0) return $urandom_range(0, 1023);
      return $urandom_range(0, lim - 1);
   endfunction

   task automatic push(census_word w);
      pending_words.push_back(w);
      issued++;
   endtask

   task automatic queue_sequence(int n, bit messy);
      int ids [$];
      int cnt, tiles, j, t, sp, dp;
      cnt = edge_goal > NumEdges ? NumEdges : edge_goal;
      for (int i = 0; i < cnt; i++) ids.push_back(i);
      ids.shuffle();
      tiles = int'(src_groups) * int'(dst_groups);
      if (tiles < 1 || tiles > NumTiles) tiles = NumTiles;
      push(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < $urandom_range(1, 6); i++)
         push(make_word(OP_SELECT, $urandom_range(0, tiles - 1), $urandom_range(0, 3) != 0,
                        0, 0, 0, 0, 0));
      if (n > cnt) n = cnt;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 1)) begin
            sp = $urandom_range(0, 1);
            dp = $urandom_range(0, 1);
         end else begin
            sp = $urandom_range(0, 15);
            dp = $urandom_range(0, 15);
         end
         push(make_word(OP_EDGE, 0, 0, group_pick(src_groups), sp, group_pick(dst_groups), dp,
                        ids[i]));
         if (messy && $urandom_range(0, 19) == 0) begin
            j = $urandom_range(0, 2);
            if (j == 0) push(make_word(OP_EDGE, 0, 0, group_pick(src_groups), sp,
                                       group_pick(dst_groups), dp, ids[i]));
            else if (j == 1) push(noise_word());
            else begin
               t = $urandom_range(0, tiles - 1);
               push(make_word(OP_SELECT, t, $urandom_range(0, 1), 0, 0, 0, 0, 0));
            end
         end
      end
      push(make_word(OP_FINISH, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_words.size() > 0 || start || expected_results.size() > 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_regs(int sg, int dg, int et);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_SOURCE_GROUPS;
      csr_data <= CsrDataW'(sg);
      @(posedge clock);
      csr_index <= CSR_DESTINATION_GROUPS;
      csr_data <= CsrDataW'(dg);
      @(posedge clock);
      csr_index <= CSR_EDGE_TOTAL;
      csr_data <= CsrDataW'(et);
      @(posedge clock);
      csr_write <= 1'b0;
      src_groups = 11'(sg);
      dst_groups = 11'(dg);
      edge_goal = 13'(et);
   endtask

   initial begin
      int cfg [10][3] = '{'{1, 1, 1}, '{4, 4, 40}, '{1024, 1, 4096}, '{1, 1024, 30},
                          '{32, 32, 8191}, '{2047, 1, 20}, '{0, 3, 10}, '{3, 2, 0},
                          '{2, 2, 16}, '{16, 8, 64}};
      int p;
      wipe_census();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      push(make_word(OP_EDGE, 0, 0, 0, 0, 0, 0, 0));
      push(make_word(OP_FINISH, 0, 0, 0, 0, 0, 0, 0));
      push(make_word(OP_EDGE, 0, 0, 0, 15, 0, 15, 0));
      push(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      push(make_word(OP_FINISH, 0, 0, 0, 0, 0, 0, 0));
      push(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      push(make_word(OP_SELECT, 1023, 1, 0, 0, 0, 0, 0));
      push(make_word(OP_EDGE, 0, 0, 1023, 0, 0, 0, 0));
      push(make_word(OP_SELECT, 0, 1, 0, 0, 0, 0, 0));
      push(make_word(OP_FINISH, 0, 0, 0, 0, 0, 0, 0));
      push(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      push(make_word(OP_EDGE, 0, 0, 0, 0, 1023, 0, 0));
      push(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      push(make_word(OP_EDGE, 0, 0, 0, 0, 0, 0, 4095));
      wait_drained();
      write_regs(2, 2, 3);
      push(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      push(make_word(OP_SELECT, 3, 1, 0, 0, 0, 0, 0));
      push(make_word(OP_EDGE, 0, 0, 1, 15, 1, 15, 0));
      push(make_word(OP_EDGE, 0, 0, 1, 15, 1, 15, 1));
      push(make_word(OP_EDGE, 0, 0, 0, 0, 0, 0, 2));
      push(make_word(OP_FINISH, 0, 0, 0, 0, 0, 0, 0));
      push(make_word(OP_EDGE, 0, 0, 0, 0, 0, 0, 1));
      push(make_word(OP_SELECT, 2, 0, 0, 0, 0, 0, 0));
      wait_drained();

      p = 0;
      while (issued < 2000) begin
         write_regs(cfg[p % 10][0], cfg[p % 10][1], cfg[p % 10][2]);
         for (int s = 0; s < 5; s++) begin
            queue_sequence($urandom_range(5, 40), $urandom_range(0, 2) == 0);
            if ($urandom_range(0, 3) == 0) push(noise_word());
         end
         wait_drained();
         p++;
      end
      repeat (20) @(posedge clock);
      if (!failed) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

@@ sim.f @@
src/toc_pkg.sv
src/tile_occupancy_census.sv
dv/tile_occupancy_census_tb.sv
